// ===== hw/rtl/pdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdt_pkg;

	localparam int unsigned MS_W  = 23;
	localparam int unsigned US_W  = 32;
	localparam int unsigned STS_W = 3;
	localparam int unsigned IDX_W = 3;

	localparam logic [MS_W-1:0] MAX_MS   = MS_W'(4294967);
	localparam logic [9:0]      SCALE_US = 10'd1000;

	localparam logic [STS_W-1:0] ST_REGISTERED = 3'd0;
	localparam logic [STS_W-1:0] ST_FULL       = 3'd1;
	localparam logic [STS_W-1:0] ST_INVALID    = 3'd2;
	localparam logic [STS_W-1:0] ST_DISPATCHED = 3'd3;
	localparam logic [STS_W-1:0] ST_NOTHING    = 3'd4;

	localparam logic CMD_REGISTER = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	// what a cell reports to the top while the scan token moves
	typedef struct packed {
		logic hit;
		logic pass;
		logic stop;
	} cell_stat_t;

	// entry loaded into a cell at registration
	typedef struct packed {
		logic [US_W-1:0] period;
		logic [US_W-1:0] duration;
		logic [US_W-1:0] first;
	} cell_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pdt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdt_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire pdt_pkg::cell_entry_t         wr_entry,
	input  wire logic                         active,
	input  wire logic                         tok_in,
	input  wire logic [pdt_pkg::US_W-1:0]     now,
	output pdt_pkg::cell_stat_t               stat,
	output logic [pdt_pkg::US_W-1:0]          duration
);

	logic [pdt_pkg::US_W-1:0] period_q;
	logic [pdt_pkg::US_W-1:0] duration_q;
	logic [pdt_pkg::US_W-1:0] last_q;
	logic                     has_run_q;
	logic                     tok_q;
	logic [pdt_pkg::US_W-1:0] elapsed;
	logic                     early;
	logic                     due;

	assign elapsed = now - last_q;
	// never run and still before its start time
	assign early   = !has_run_q && (now < last_q);
	assign due     = !early && (elapsed >= period_q);

	assign stat.hit  = tok_q && active && due;
	assign stat.pass = tok_q && active && !due;
	assign stat.stop = tok_q && !active;
	assign duration  = duration_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			period_q   <= wr_entry.period;
			duration_q <= wr_entry.duration;
			last_q     <= wr_entry.first;
			has_run_q  <= 1'b0;
		end else if (stat.hit) begin
			last_q    <= now;
			has_run_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_task_dispatcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Periodic task dispatcher. Each request word yields one result word. A register
// request (cmd 0) scales period, start delay and duration from ms to us and,
// unless the slots are full or a value is invalid, stores the task in the next
// free slot; its result passes the scale, write and post states to the output
// register. A dispatch request (cmd 1) sends a token down the row of task cells,
// one cell per cycle, and the first registered cell whose elapsed time since its
// last run reaches its period is taken; its result passes the scan and post states
// to the output register. A new request is taken the cycle after the result is
// loaded. One request is in work at a time; a finished result sits in the output
// register, so the next request can be accepted while that result is still stalled.
module periodic_task_dispatcher #(
	parameter int unsigned TASK_SLOTS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          cmd,
	input  wire logic [pdt_pkg::MS_W-1:0]      period_ms,
	input  wire logic [pdt_pkg::MS_W-1:0]      start_ms,
	input  wire logic [pdt_pkg::MS_W-1:0]      duration_ms,
	input  wire logic [pdt_pkg::US_W-1:0]      now,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [pdt_pkg::STS_W-1:0]          status,
	output logic [pdt_pkg::IDX_W-1:0]          task_index,
	output logic [pdt_pkg::US_W-1:0]           watch_duration
);

	localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
	localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int unsigned PW = pdt_pkg::MS_W + 10;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCALE = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_POST  = 3'd4;

	logic [2:0]                  state_q;
	logic [CW-1:0]               count_q;
	logic [pdt_pkg::MS_W-1:0]    per_ms_q;
	logic [pdt_pkg::MS_W-1:0]    del_ms_q;
	logic [pdt_pkg::MS_W-1:0]    dur_ms_q;
	logic [pdt_pkg::US_W-1:0]    now_q;
	pdt_pkg::cell_entry_t        entry_q;
	logic [pdt_pkg::STS_W-1:0]   res_sts_q;
	logic [pdt_pkg::IDX_W-1:0]   res_idx_q;
	logic [pdt_pkg::US_W-1:0]    res_dur_q;
	logic                        out_valid_q;
	logic [pdt_pkg::STS_W-1:0]   out_sts_q;
	logic [pdt_pkg::IDX_W-1:0]   out_idx_q;
	logic [pdt_pkg::US_W-1:0]    out_dur_q;

	logic                        accept;
	logic                        out_free;
	logic                        start;
	logic [PW-1:0]               per_prod;
	logic [PW-1:0]               del_prod;
	logic [PW-1:0]               dur_prod;
	logic                        bad;

	pdt_pkg::cell_stat_t         stat [TASK_SLOTS];
	logic [pdt_pkg::US_W-1:0]    cell_dur [TASK_SLOTS];
	logic [TASK_SLOTS-1:0]       tok;
	logic [TASK_SLOTS-1:0]       wr_en;
	logic [TASK_SLOTS-1:0]       active;

	logic                        hit_any;
	logic                        stop_any;
	logic [pdt_pkg::US_W-1:0]    hit_dur;
	logic [IW-1:0]               hit_idx;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign start    = (state_q == S_IDLE) && accept && (cmd == pdt_pkg::CMD_DISPATCH);

	assign per_prod = PW'(per_ms_q) * PW'(pdt_pkg::SCALE_US);
	assign del_prod = PW'(del_ms_q) * PW'(pdt_pkg::SCALE_US);
	assign dur_prod = PW'(dur_ms_q) * PW'(pdt_pkg::SCALE_US);
	assign bad = (per_ms_q == '0) || (dur_ms_q == '0) || (per_ms_q > pdt_pkg::MAX_MS)
		|| (dur_ms_q > pdt_pkg::MAX_MS) || (del_ms_q > pdt_pkg::MAX_MS);

	// row of task cells, the scan token steps one cell per cycle
	for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
		assign active[i] = (CW'(i) < count_q);
		assign wr_en[i]  = (state_q == S_WRITE) && (res_sts_q == pdt_pkg::ST_REGISTERED)
			&& (count_q == CW'(i));
		if (i == 0) begin : g_head
			assign tok[i] = start;
		end else begin : g_link
			assign tok[i] = stat[i-1].pass;
		end
		pdt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en[i]),
			.wr_entry (entry_q),
			.active   (active[i]),
			.tok_in   (tok[i]),
			.now      (now_q),
			.stat     (stat[i]),
			.duration (cell_dur[i])
		);
	end

	always_comb begin
		hit_any  = 1'b0;
		stop_any = stat[TASK_SLOTS-1].pass;
		hit_dur  = '0;
		hit_idx  = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			hit_any  = hit_any | stat[i].hit;
			stop_any = stop_any | stat[i].stop;
			hit_dur  = hit_dur | (stat[i].hit ? cell_dur[i] : '0);
			if (stat[i].hit) begin
				hit_idx = IW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cmd == pdt_pkg::CMD_DISPATCH) ? S_SCAN : S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (res_sts_q == pdt_pkg::ST_REGISTERED) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= S_POST;
				end
				S_SCAN: begin
					if (hit_any || stop_any) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			per_ms_q <= period_ms;
			del_ms_q <= start_ms;
			dur_ms_q <= duration_ms;
			now_q    <= now;
		end
		if (state_q == S_SCALE) begin
			entry_q.period   <= per_prod[pdt_pkg::US_W-1:0];
			entry_q.duration <= dur_prod[pdt_pkg::US_W-1:0];
			entry_q.first    <= del_prod[pdt_pkg::US_W-1:0];
			res_dur_q        <= '0;
			if (count_q >= CW'(TASK_SLOTS)) begin
				res_sts_q <= pdt_pkg::ST_FULL;
				res_idx_q <= '0;
			end else if (bad) begin
				res_sts_q <= pdt_pkg::ST_INVALID;
				res_idx_q <= '0;
			end else begin
				res_sts_q <= pdt_pkg::ST_REGISTERED;
				res_idx_q <= pdt_pkg::IDX_W'(count_q);
			end
		end
		if (state_q == S_SCAN) begin
			if (hit_any) begin
				res_sts_q <= pdt_pkg::ST_DISPATCHED;
				res_idx_q <= pdt_pkg::IDX_W'(hit_idx);
				res_dur_q <= hit_dur;
			end else begin
				res_sts_q <= pdt_pkg::ST_NOTHING;
				res_idx_q <= '0;
				res_dur_q <= '0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_POST);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (state_q == S_POST)) begin
			out_sts_q <= res_sts_q;
			out_idx_q <= res_idx_q;
			out_dur_q <= res_dur_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_sts_q;
	assign task_index     = out_idx_q;
	assign watch_duration = out_dur_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pdt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [pdt_pkg::STS_W-1:0]     status,
	input wire logic [pdt_pkg::IDX_W-1:0]     task_index,
	input wire logic [pdt_pkg::US_W-1:0]      watch_duration
);

	// one request in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a request is in work");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == pdt_pkg::ST_REGISTERED) || (status == pdt_pkg::ST_FULL)
			|| (status == pdt_pkg::ST_INVALID) || (status == pdt_pkg::ST_DISPATCHED)
			|| (status == pdt_pkg::ST_NOTHING))
		else $error("status code out of range");

	a_dur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != pdt_pkg::ST_DISPATCHED) |-> watch_duration == '0)
		else $error("duration set on a word that is not a dispatch");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == pdt_pkg::ST_FULL) || (status == pdt_pkg::ST_INVALID)
			|| (status == pdt_pkg::ST_NOTHING)) |-> task_index == '0)
		else $error("index set on a refused or empty result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(task_index)
			&& $stable(watch_duration))
		else $error("stalled output word changed");

endmodule

bind periodic_task_dispatcher pdt_checker u_pdt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.task_index     (task_index),
	.watch_duration (watch_duration)
);

`default_nettype wire
